// ===== rtl/i2ctqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctqs_pkg
// shared types and constants of the i2c transaction queue sequencer
// ----------------------------------------------------------------------------
package i2ctqs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int REQ_W       = 31;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = '1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WRITE_TIMEOUT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_READ_TIMEOUT  = 1'b1;

    // transfer status codes from the bus driver
    localparam logic [1:0] XFER_COMPLETE = 2'd1;
    localparam logic [1:0] XFER_ERROR    = 2'd2;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_TICK    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_START   = 3'd1,
        ST_WRITE   = 3'd2,
        ST_RESTART = 3'd3,
        ST_READ    = 3'd4,
        ST_CLOSE   = 3'd5
    } seq_state_t;

    typedef enum logic [2:0] {
        CS_NONE    = 3'd0,
        CS_REQ     = 3'd1,
        CS_DONE    = 3'd2,
        CS_ERROR   = 3'd3,
        CS_TIMEOUT = 3'd4
    } client_status_t;

    typedef enum logic {
        PH_ACCEPT = 1'b0,
        PH_FETCH  = 1'b1
    } phase_t;

    typedef struct packed {
        logic [6:0] address;
        logic [7:0] write_len;
        logic [7:0] read_len;
        logic [7:0] tag;
    } req_t;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0]     tag;
        logic [7:0]     read_len;
        logic [7:0]     write_len;
        logic [6:0]     address;
        logic           release_bus;
        logic           issue_read;
        logic           issue_write;
        logic           open_bus;
        seq_state_t     engine_state;
        client_status_t client_status;
        logic           add_accepted;
    } res_t;

endpackage

// ===== rtl/i2ctqs_ring_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctqs_ring_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module i2ctqs_ring_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 31,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2c_transaction_queue_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_transaction_queue_sequencer
// request ring in block ram plus a step driven i2c transaction sequencer
// ----------------------------------------------------------------------------
// ordering: a result word is registered as its input word is taken; a step
//   that dequeues a request first reads the ring ram, then registers its result
// throughput: one word per cycle while m_tready does not stall the result; a
//   dequeuing step holds s_tready low while the ring entry is read
// reset: synchronous active low; clears pointers, engine state, current
//   request, status, elapsed counter and sets both timeouts to 100 ticks; ring
//   contents are not cleared, no clearing pass
module i2c_transaction_queue_sequencer
    import i2ctqs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TIMEOUT_W-1:0]  cfg_wdata,

    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // req_address[6:0] req_write_len[14:7] req_read_len[22:15] req_tag[30:23]
    // launch_accepted[31] transfer_status[33:32], zero pad to 40
    input  logic [39:0]           s_tdata,
    // mode[1:0]
    input  logic [1:0]            s_tuser,

    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // add_accepted[0] client_status[3:1] engine_state[6:4] open_bus[7]
    // issue_write[8] issue_read[9] release_bus[10] cur_address[17:11]
    // cur_write_len[25:18] cur_read_len[33:26] cur_tag[41:34], zero pad to 48
    output logic [47:0]           m_tdata
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [TIMEOUT_W-1:0] wr_timeout_reg, wr_timeout_next;
    logic [TIMEOUT_W-1:0] rd_timeout_reg, rd_timeout_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    seq_state_t           seq_state_reg, seq_state_next;
    client_status_t       status_reg, status_next;
    req_t                 cur_req_reg, cur_req_next;
    logic [TIMEOUT_W-1:0] elapsed_reg, elapsed_next;
    phase_t               phase_reg, phase_next;
    logic                 m_valid_reg, m_valid_next;
    res_t                 res_reg, res_next;

    // ------------------------------------------------------------------
    // input word fields
    // ------------------------------------------------------------------
    req_t       in_req;
    logic       in_launch;
    logic [1:0] in_xfer;
    mode_t      in_mode;

    assign in_req.address   = s_tdata[6:0];
    assign in_req.write_len = s_tdata[14:7];
    assign in_req.read_len  = s_tdata[22:15];
    assign in_req.tag       = s_tdata[30:23];
    assign in_launch        = s_tdata[31];
    assign in_xfer          = s_tdata[33:32];
    assign in_mode          = mode_t'(s_tuser);

    // ------------------------------------------------------------------
    // ring ram
    // ------------------------------------------------------------------
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [REQ_W-1:0] ram_rd_data;
    req_t             fetched_req;

    i2ctqs_ring_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REQ_W),
        .AW    (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (in_req),
        .rd_en   (ram_rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    assign fetched_req = req_t'(ram_rd_data);

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic in_take;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (phase_reg == PH_ACCEPT) && out_free;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, res_reg};

    // ring pointer arithmetic
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             ring_full;
    logic             ring_empty;

    assign wp_inc     = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc     = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign ring_full  = (wp_inc == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);

    // ------------------------------------------------------------------
    // next state and result
    // ------------------------------------------------------------------
    always_comb begin
        logic                 add_ok;
        logic                 open_b;
        logic                 iss_w;
        logic                 iss_r;
        logic                 rel;
        logic [TIMEOUT_W-1:0] limit;
        logic                 more;

        wr_timeout_next = wr_timeout_reg;
        rd_timeout_next = rd_timeout_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        seq_state_next  = seq_state_reg;
        status_next     = status_reg;
        cur_req_next    = cur_req_reg;
        elapsed_next    = elapsed_reg;
        phase_next      = phase_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        res_next        = res_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        add_ok          = 1'b0;
        open_b          = 1'b0;
        iss_w           = 1'b0;
        iss_r           = 1'b0;
        rel             = 1'b0;
        limit           = wr_timeout_reg;
        more            = 1'b0;

        // the user must write the registers only while the block is idle; the block itself does not enforce this
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WRITE_TIMEOUT: wr_timeout_next = cfg_wdata;
                REG_READ_TIMEOUT:  rd_timeout_next = cfg_wdata;
                default: ;
            endcase
        end

        if (phase_reg == PH_FETCH) begin
            // ring entry already read, finish the dequeue step once the output is free
            if (out_free) begin
                cur_req_next = fetched_req;
                phase_next   = PH_ACCEPT;
                m_valid_next = 1'b1;
                res_next     = '{
                    tag:           fetched_req.tag,
                    read_len:      fetched_req.read_len,
                    write_len:     fetched_req.write_len,
                    address:       fetched_req.address,
                    release_bus:   1'b0,
                    issue_read:    1'b0,
                    issue_write:   1'b0,
                    open_bus:      1'b1,
                    engine_state:  seq_state_reg,
                    client_status: status_reg,
                    add_accepted:  1'b0
                };
            end
        end else if (in_take) begin
            case (in_mode)
                MODE_ENQUEUE: begin
                    if (!ring_full) begin
                        ram_wr_en = 1'b1;
                        wp_next   = wp_inc;
                        add_ok    = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (elapsed_reg != ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                MODE_STEP: begin
                    case (seq_state_reg)
                        ST_IDLE: begin
                            if (!ring_empty) begin
                                ram_rd_en      = 1'b1;
                                rp_next        = rp_inc;
                                status_next    = CS_REQ;
                                seq_state_next = ST_START;
                                phase_next     = PH_FETCH;
                            end
                        end
                        ST_START: begin
                            iss_w = 1'b1;
                            if (in_launch) begin
                                elapsed_next   = '0;
                                seq_state_next = ST_WRITE;
                            end
                        end
                        ST_RESTART: begin
                            iss_r = 1'b1;
                            if (in_launch) begin
                                elapsed_next   = '0;
                                seq_state_next = ST_READ;
                            end
                        end
                        ST_WRITE, ST_READ: begin
                            if (seq_state_reg == ST_WRITE) begin
                                limit = wr_timeout_reg;
                                more  = (cur_req_reg.read_len != 8'd0);
                            end else begin
                                limit = rd_timeout_reg;
                                more  = 1'b0;
                            end
                            // status code 3 counts as pending
                            if (in_xfer == XFER_ERROR) begin
                                status_next    = CS_ERROR;
                                seq_state_next = ST_CLOSE;
                            end else if (in_xfer == XFER_COMPLETE) begin
                                if (more) begin
                                    seq_state_next = ST_RESTART;
                                end else begin
                                    status_next    = CS_DONE;
                                    seq_state_next = ST_CLOSE;
                                end
                            end else if (elapsed_reg > limit) begin
                                status_next    = CS_TIMEOUT;
                                seq_state_next = ST_CLOSE;
                            end
                        end
                        ST_CLOSE: begin
                            rel            = 1'b1;
                            seq_state_next = ST_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            // dequeue result waits for the ring read
            if (phase_next == PH_ACCEPT) begin
                m_valid_next = 1'b1;
                res_next     = '{
                    tag:           cur_req_reg.tag,
                    read_len:      cur_req_reg.read_len,
                    write_len:     cur_req_reg.write_len,
                    address:       cur_req_reg.address,
                    release_bus:   rel,
                    issue_read:    iss_r,
                    issue_write:   iss_w,
                    open_bus:      open_b,
                    engine_state:  seq_state_next,
                    client_status: status_next,
                    add_accepted:  add_ok
                };
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_timeout_reg <= TIMEOUT_RESET;
            rd_timeout_reg <= TIMEOUT_RESET;
            wp_reg         <= '0;
            rp_reg         <= '0;
            seq_state_reg  <= ST_IDLE;
            status_reg     <= CS_NONE;
            cur_req_reg    <= '0;
            elapsed_reg    <= '0;
            phase_reg      <= PH_ACCEPT;
            m_valid_reg    <= 1'b0;
        end else begin
            wr_timeout_reg <= wr_timeout_next;
            rd_timeout_reg <= rd_timeout_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            seq_state_reg  <= seq_state_next;
            status_reg     <= status_next;
            cur_req_reg    <= cur_req_next;
            elapsed_reg    <= elapsed_next;
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

// ===== tb/sv/i2c_transaction_queue_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_transaction_queue_sequencer_test
// self-checking bench: a directed table and random phases under varied
// idling; every result word is checked field by field against its table
// entry or an in-bench model of the request ring and the transaction engine
// ----------------------------------------------------------------------------
module i2c_transaction_queue_sequencer_test;
    import i2ctqs_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_RESERVED = 2'd3;   // unused mode, changes nothing
    localparam logic [1:0] XFER_PENDING  = 2'd0;
    localparam logic [1:0] XFER_RESERVED = 2'd3;   // behaves as pending

    // result words that can be read off directly before any dequeue
    localparam logic [41:0] RES_IDLE  = 42'd0;     // nothing happened, engine idle
    localparam logic [41:0] RES_ADDED = 42'd1;     // only add_accepted set

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 165;

    // per phase register settings and enqueue weight
    int unsigned phase_wto [PHASES] = '{0, 1, 65535, 5, 2, 0, 65535, 3};
    int unsigned phase_rto [PHASES] = '{0, 3, 65535, 2, 7, 65535, 0, 1};
    int unsigned phase_enq [PHASES] = '{25, 35, 15, 30, 40, 20, 30, 25};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [TIMEOUT_W-1:0]  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;

    i2c_transaction_queue_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------
    req_t                 ring [QUEUE_DEPTH];
    int                   ring_wr;
    int                   ring_rd;
    seq_state_t           eng;
    req_t                 cur;
    client_status_t       cstat;
    logic [TIMEOUT_W-1:0] elapsed;
    logic [TIMEOUT_W-1:0] wto;
    logic [TIMEOUT_W-1:0] rto;

    res_t engine_reports [$];   // result words still owed by the block
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    typedef struct packed {
        logic [1:0] mode;
        req_t       rq;
        logic       acc;
        logic [1:0] xs;
        logic       typed;
        res_t       want;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic int slot_after(input int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // pending write or read: error and complete win over the timeout
    function automatic void settle_transfer(input logic [1:0] xs,
            input logic [TIMEOUT_W-1:0] limit, input logic more);
        if (xs == XFER_ERROR) begin
            cstat = CS_ERROR;
            eng   = ST_CLOSE;
        end else if (xs == XFER_COMPLETE) begin
            if (more) begin
                eng = ST_RESTART;
            end else begin
                cstat = CS_DONE;
                eng   = ST_CLOSE;
            end
        end else if (elapsed > limit) begin
            cstat = CS_TIMEOUT;
            eng   = ST_CLOSE;
        end
    endfunction

    function automatic res_t step_engine(input logic [1:0] mode, input req_t rq,
            input logic acc, input logic [1:0] xs);
        res_t r;
        r = '0;
        case (mode)
            MODE_ENQUEUE: begin
                // one slot stays free, a full ring drops the request
                if (slot_after(ring_wr) != ring_rd) begin
                    ring[ring_wr]  = rq;
                    ring_wr        = slot_after(ring_wr);
                    r.add_accepted = 1'b1;
                end
            end
            MODE_TICK: begin
                if (elapsed != ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
            end
            MODE_STEP: begin
                case (eng)
                    ST_IDLE: begin
                        if (ring_wr != ring_rd) begin
                            cur        = ring[ring_rd];
                            ring_rd    = slot_after(ring_rd);
                            cstat      = CS_REQ;
                            eng        = ST_START;
                            r.open_bus = 1'b1;
                        end
                    end
                    ST_START: begin
                        r.issue_write = 1'b1;
                        if (acc) begin
                            elapsed = '0;
                            eng     = ST_WRITE;
                        end
                    end
                    ST_WRITE: settle_transfer(xs, wto, cur.read_len != 8'd0);
                    ST_RESTART: begin
                        r.issue_read = 1'b1;
                        if (acc) begin
                            elapsed = '0;
                            eng     = ST_READ;
                        end
                    end
                    ST_READ: settle_transfer(xs, rto, 1'b0);
                    ST_CLOSE: begin
                        r.release_bus = 1'b1;
                        eng           = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.client_status = cstat;
        r.engine_state  = eng;
        r.address       = cur.address;
        r.write_len     = cur.write_len;
        r.read_len      = cur.read_len;
        r.tag           = cur.tag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic push_word(input logic [1:0] mode, input req_t rq, input logic acc,
            input logic [1:0] xs, input logic typed, input res_t want);
        res_t got;
        // sender gaps
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, xs, acc, rq.tag, rq.read_len, rq.write_len, rq.address};
        do
            @(posedge aclk);
        while (!s_tready);
        // word taken at this edge
        got = step_engine(mode, rq, acc, xs);
        engine_reports.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    task automatic rand_word(input int enq_pct);
        int   r;
        int   sr;
        logic [1:0] mode;
        logic [1:0] xs;
        r = $urandom_range(99);
        if (r < enq_pct)
            mode = MODE_ENQUEUE;
        else if (r < enq_pct + 20)
            mode = MODE_TICK;
        else if (r < 98)
            mode = MODE_STEP;
        else
            mode = MODE_RESERVED;
        sr = $urandom_range(99);
        if (sr < 35)
            xs = XFER_PENDING;
        else if (sr < 45)
            xs = XFER_RESERVED;
        else if (sr < 80)
            xs = XFER_COMPLETE;
        else
            xs = XFER_ERROR;
        push_word(mode, req_t'($urandom), $urandom_range(99) < 70, xs, 1'b0, '0);
    endtask

    // stop sending and wait until every owed word has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (engine_reports.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // only called with the block drained
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
            input logic [TIMEOUT_W-1:0] val);
        repeat (3) @(negedge aclk);   // let any trailing step settle
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_WRITE_TIMEOUT)
            wto = val;
        else
            rto = val;
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [6:0] a,
            input logic [7:0] w, input logic [7:0] rl, input logic [7:0] t,
            input logic acc, input logic [1:0] xs, input logic typed,
            input logic [41:0] want);
        stim_row_t row;
        row.mode  = mode;
        row.rq    = {a, w, rl, t};
        row.acc   = acc;
        row.xs    = xs;
        row.typed = typed;
        row.want  = res_t'(want);
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // receiver and result checking
    // ------------------------------------------------------------------------
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[41:0]);
            if (engine_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected word expected none actual %h", $time, m_tdata);
            end else begin
                want = engine_reports.pop_front();
                check_field("add_accepted", 32'(want.add_accepted), 32'(got.add_accepted));
                check_field("client_status", 32'(want.client_status),
                            32'(got.client_status));
                check_field("engine_state", 32'(want.engine_state), 32'(got.engine_state));
                check_field("open_bus", 32'(want.open_bus), 32'(got.open_bus));
                check_field("issue_write", 32'(want.issue_write), 32'(got.issue_write));
                check_field("issue_read", 32'(want.issue_read), 32'(got.issue_read));
                check_field("release_bus", 32'(want.release_bus), 32'(got.release_bus));
                check_field("cur_address", 32'(want.address), 32'(got.address));
                check_field("cur_write_len", 32'(want.write_len), 32'(got.write_len));
                check_field("cur_read_len", 32'(want.read_len), 32'(got.read_len));
                check_field("cur_tag", 32'(want.tag), 32'(got.tag));
                check_field("pad", 32'd0, 32'(m_tdata[47:42]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        ring_wr   = 0;
        ring_rd   = 0;
        eng       = ST_IDLE;
        cur       = '0;
        cstat     = CS_NONE;
        elapsed   = '0;
        wto       = TIMEOUT_RESET;
        rto       = TIMEOUT_RESET;

        // empty ring step, unused mode and a tick all give the idle result word
        add_row(MODE_STEP, 7'h55, 8'haa, 8'h55, 8'haa, 1'b1, XFER_COMPLETE, 1'b1, RES_IDLE);
        add_row(MODE_RESERVED, 7'h2a, 8'h55, 8'haa, 8'h55, 1'b0, XFER_ERROR, 1'b1, RES_IDLE);
        add_row(MODE_TICK, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, XFER_RESERVED, 1'b1, RES_IDLE);
        // fill the ring to its usable depth, extremes first
        add_row(MODE_ENQUEUE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, XFER_ERROR, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h01, 8'h02, 8'h00, 8'h03, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h40, 8'h80, 8'h01, 8'h80, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h55, 8'haa, 8'h55, 8'haa, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h2a, 8'h55, 8'haa, 8'h55, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        add_row(MODE_ENQUEUE, 7'h7e, 8'hfe, 8'hfe, 8'hfe, 1'b0, XFER_PENDING, 1'b1, RES_ADDED);
        // ring full, request dropped
        add_row(MODE_ENQUEUE, 7'h03, 8'h03, 8'h03, 8'h03, 1'b0, XFER_PENDING, 1'b1, RES_IDLE);
        // full write then read: refused launches, reserved status, read error
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_RESERVED, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_COMPLETE, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_ERROR, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);
        // zero read length: write completes straight to done
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, XFER_PENDING, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_COMPLETE, 1'b0, '0);
        add_row(MODE_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, XFER_PENDING, 1'b0, '0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            push_word(directed_rows[i].mode, directed_rows[i].rq, directed_rows[i].acc,
                      directed_rows[i].xs, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // random phases, each with its own registers and idling mix
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_WRITE_TIMEOUT, TIMEOUT_W'(phase_wto[p]));
            write_reg(REG_READ_TIMEOUT, TIMEOUT_W'(phase_rto[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            @(negedge aclk);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // mid phase the sender holds off until the block has caught up
                if (n == PHASE_WORDS / 2)
                    drain_results();
                rand_word(int'(phase_enq[p]));
            end
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && engine_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2ctqs_pkg.sv
rtl/i2ctqs_ring_ram.sv
rtl/i2c_transaction_queue_sequencer.sv
tb/sv/i2c_transaction_queue_sequencer_test.sv
